>>> src/qlte_pkg.sv
// ----------------------------------------------------------------------------
// qlte_pkg: shared constants of the Q-learning table engine
// Field widths, command codes, CSR register indexes, reset values and decay constants.
// ----------------------------------------------------------------------------
package qlte_pkg;

   // Transaction field widths
   localparam int CMD_W      = 2;
   localparam int STATE_W    = 8;
   localparam int ACTION_W   = 2;
   localparam int REWARD_W   = 32;
   localparam int DRAW_W     = 7;
   localparam int NEWVAL_W   = 32;
   localparam int RATE_W     = 7;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CHOOSE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UPDATE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EPISODE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd3;

   // CSR register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCOUNT_FACTOR     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_EXPLORATION = 2'd2;

   // Reset values
   localparam logic [FRAC_W-1:0] ALPHA_RESET = 16'd6554;
   localparam logic [FRAC_W-1:0] GAMMA_RESET = 16'd58982;
   localparam logic [RATE_W-1:0] RATE_RESET  = 7'd100;

   // Exploration decay
   localparam logic [RATE_W-1:0] DECAY_FLOOR = 7'd10;
   localparam logic [RATE_W-1:0] DECAY_STEP  = 7'd2;

endpackage

>>> src/qlte_if.sv
// ----------------------------------------------------------------------------
// qlte_if: channel interfaces of the Q-learning table engine
// Request, response and CSR write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface qlte_req_if;
   import qlte_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     cmd;
   logic [STATE_W-1:0]   state_index;
   logic [ACTION_W-1:0]  action_index;
   logic [REWARD_W-1:0]  reward;
   logic [STATE_W-1:0]   next_state_index;
   logic [DRAW_W-1:0]    random_draw;
   logic [ACTION_W-1:0]  random_action;

   modport source (output valid, cmd, state_index, action_index, reward,
                   next_state_index, random_draw, random_action, input ready);
   modport sink   (input valid, cmd, state_index, action_index, reward,
                   next_state_index, random_draw, random_action, output ready);
endinterface

interface qlte_rsp_if;
   import qlte_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  chosen_action;
   logic                 was_random;
   logic [NEWVAL_W-1:0]  new_value;
   logic [RATE_W-1:0]    exploration_now;

   modport source (output valid, chosen_action, was_random, new_value,
                   exploration_now, input ready);
   modport sink   (input valid, chosen_action, was_random, new_value,
                   exploration_now, output ready);
endinterface

interface qlte_csr_if;
   import qlte_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/q_learning_table_engine.sv
// ----------------------------------------------------------------------------
// q_learning_table_engine: tabular Q-learning with epsilon-greedy choice
// Update reads two rows, multiplies by gamma and alpha and writes back; choose reads
// one row; episode and restart go straight to the response. One transaction at a
// time; the next request is taken the cycle after the response loads. Reset:
// synchronous; a clearing pass over every row zeroes the table with req_ready low
// until it ends. CSR writes are taken at all times.
// ----------------------------------------------------------------------------
module q_learning_table_engine #(
   parameter int NUM_STATES  = 256,
   parameter int NUM_ACTIONS = 4,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   qlte_req_if.sink    req_if,
   qlte_rsp_if.source  rsp_if,
   qlte_csr_if.sink    csr_if
);
   import qlte_pkg::*;

   localparam int AW    = $clog2(NUM_STATES);
   localparam int AIW   = $clog2(NUM_ACTIONS);
   localparam int ROW_W = NUM_ACTIONS * VALUE_WIDTH;
   localparam int GP_W  = VALUE_WIDTH + FRAC_W + 1;
   localparam int G_W   = GP_W - FRAC_W;
   localparam int D_W   = ((VALUE_WIDTH + 1 > REWARD_W) ? VALUE_WIDTH + 1 : REWARD_W) + 2;
   localparam int AP_W  = D_W + FRAC_W + 1;
   localparam int A_W   = AP_W - FRAC_W;
   localparam int S_W   = A_W + 1;
   localparam int XW    = (VALUE_WIDTH > NEWVAL_W) ? VALUE_WIDTH : NEWVAL_W;

   localparam logic signed [S_W-1:0] SAT_MAX = {{(S_W-VALUE_WIDTH+1){1'b0}},
                                                {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [S_W-1:0] SAT_MIN = {{(S_W-VALUE_WIDTH+1){1'b1}},
                                                {(VALUE_WIDTH-1){1'b0}}};

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ROW1 = 3'd1;
   localparam logic [2:0] ST_ROW2 = 3'd2;
   localparam logic [2:0] ST_DIFF = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   // Control state
   logic [2:0]          state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [FRAC_W-1:0]   alpha_ff, alpha_in;
   logic [FRAC_W-1:0]   gamma_ff, gamma_in;
   logic [RATE_W-1:0]   init_rate_ff, init_rate_in;

   // Transaction held during processing
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [STATE_W-1:0]  s_ff, s_in;
   logic [ACTION_W-1:0] a_ff, a_in;
   logic signed [REWARD_W-1:0] reward_ff, reward_in;
   logic [DRAW_W-1:0]   draw_ff, draw_in;
   logic [ACTION_W-1:0] ract_ff, ract_in;
   logic                s_ok_ff, s_ok_in;
   logic                a_ok_ff, a_ok_in;
   logic                oob1_ff, oob1_in;

   // Datapath
   logic signed [VALUE_WIDTH-1:0] max_ff, max_in;
   logic [AIW-1:0]                best_ff, best_in;
   logic                          eq_ff, eq_in;
   logic [NUM_ACTIONS-1:0][VALUE_WIDTH-1:0] row_ff, row_in;
   logic signed [VALUE_WIDTH-1:0] q_ff, q_in;
   logic signed [GP_W-1:0]        gprod_ff, gprod_in;
   logic signed [D_W-1:0]         d_ff, d_in;
   logic signed [AP_W-1:0]        aprod_ff, aprod_in;

   // Response payload
   logic [ACTION_W-1:0] chosen_ff, chosen_in;
   logic                random_ff, random_in;
   logic [NEWVAL_W-1:0] nv_ff, nv_in;
   logic [RATE_W-1:0]   expl_ff, expl_in;

   // Memory and scan signals
   logic                 mem_rd_en;
   logic [AW-1:0]        mem_rd_addr;
   logic [ROW_W-1:0]     mem_rd_data;
   logic                 mem_wr_en;
   logic [NUM_ACTIONS-1:0][VALUE_WIDTH-1:0] wr_row;
   logic                 clear_busy;
   logic [NUM_ACTIONS-1:0][VALUE_WIDTH-1:0] rd_row;
   logic [NUM_ACTIONS-1:0][VALUE_WIDTH-1:0] scan_row;
   logic signed [VALUE_WIDTH-1:0] scan_max;
   logic [AIW-1:0]       scan_best;
   logic                 scan_eq;

   logic                 req_fire, csr_fire, rsp_free;
   logic [ACTION_W-1:0]  ract_mod;
   logic                 req_s_ok, req_ns_ok;
   logic [AIW-1:0]       col_sel;
   logic signed [G_W-1:0]   g_val;
   logic signed [A_W-1:0]   a_val;
   logic signed [S_W-1:0]   sum_val;
   logic signed [VALUE_WIDTH-1:0] r_sat;
   logic signed [XW-1:0]    r_ext;

   assign req_fire = req_if.valid && req_if.ready;
   assign csr_fire = csr_if.valid && csr_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   // Fold the random action into range (at most one subtract)
   assign ract_mod = (32'(req_if.random_action) >= 32'(NUM_ACTIONS)) ?
                     req_if.random_action - ACTION_W'(NUM_ACTIONS) : req_if.random_action;
   assign req_s_ok  = 32'(req_if.state_index) < 32'(NUM_STATES);
   assign req_ns_ok = 32'(req_if.next_state_index) < 32'(NUM_STATES);

   assign rd_row   = mem_rd_data;
   assign scan_row = oob1_ff ? '0 : rd_row;
   assign col_sel  = AIW'(a_ff);

   // Temporal-difference arithmetic
   assign g_val   = $signed(gprod_ff[GP_W-1:FRAC_W]);
   assign a_val   = $signed(aprod_ff[AP_W-1:FRAC_W]);
   assign sum_val = S_W'(q_ff) + S_W'(a_val);
   always_comb begin
      if (sum_val > SAT_MAX) begin
         r_sat = SAT_MAX[VALUE_WIDTH-1:0];
      end else if (sum_val < SAT_MIN) begin
         r_sat = SAT_MIN[VALUE_WIDTH-1:0];
      end else begin
         r_sat = sum_val[VALUE_WIDTH-1:0];
      end
   end
   assign r_ext = XW'(r_sat);

   // Write-back row: the updated entry replaces its column
   always_comb begin
      wr_row = row_ff;
      if (a_ok_ff) begin
         wr_row[col_sel] = r_sat;
      end
   end

   qlte_table_mem #(
      .DEPTH (NUM_STATES),
      .WIDTH (ROW_W)
   ) u_table_mem (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_data    (mem_rd_data),
      .wr_en      (mem_wr_en),
      .wr_addr    (AW'(s_ff)),
      .wr_data    (wr_row),
      .clear_busy (clear_busy)
   );

   qlte_row_max #(
      .NUM_ACTIONS (NUM_ACTIONS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_row_max (
      .row        (scan_row),
      .max_value  (scan_max),
      .best_index (scan_best),
      .all_equal  (scan_eq)
   );

   // Sequencer: read rows, multiply, write back, load the response
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rate_in      = rate_ff;
      alpha_in     = alpha_ff;
      gamma_in     = gamma_ff;
      init_rate_in = init_rate_ff;
      cmd_in       = cmd_ff;
      s_in         = s_ff;
      a_in         = a_ff;
      reward_in    = reward_ff;
      draw_in      = draw_ff;
      ract_in      = ract_ff;
      s_ok_in      = s_ok_ff;
      a_ok_in      = a_ok_ff;
      oob1_in      = oob1_ff;
      max_in       = max_ff;
      best_in      = best_ff;
      eq_in        = eq_ff;
      row_in       = row_ff;
      q_in         = q_ff;
      gprod_in     = gprod_ff;
      d_in         = d_ff;
      aprod_in     = aprod_ff;
      chosen_in    = chosen_ff;
      random_in    = random_ff;
      nv_in        = nv_ff;
      expl_in      = expl_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = AW'(s_ff);
      mem_wr_en    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_if.cmd;
               s_in      = req_if.state_index;
               a_in      = req_if.action_index;
               reward_in = $signed(req_if.reward);
               draw_in   = req_if.random_draw;
               ract_in   = ract_mod;
               s_ok_in   = req_s_ok;
               a_ok_in   = 32'(req_if.action_index) < 32'(NUM_ACTIONS);
               mem_rd_en = 1'b1;
               if (req_if.cmd == CMD_UPDATE) begin
                  mem_rd_addr = AW'(req_if.next_state_index);
                  oob1_in     = !req_ns_ok;
               end else begin
                  mem_rd_addr = AW'(req_if.state_index);
                  oob1_in     = !req_s_ok;
               end
               if (req_if.cmd == CMD_CHOOSE || req_if.cmd == CMD_UPDATE) begin
                  state_in = ST_ROW1;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ROW1: begin
            max_in  = scan_max;
            best_in = scan_best;
            eq_in   = scan_eq;
            if (cmd_ff == CMD_UPDATE) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(s_ff);
               state_in    = ST_ROW2;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ROW2: begin
            row_in   = rd_row;
            q_in     = '0;
            if (s_ok_ff && a_ok_ff) begin
               q_in = $signed(rd_row[col_sel]);
            end
            gprod_in = GP_W'(max_ff) * GP_W'($signed({1'b0, gamma_ff}));
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            d_in     = D_W'(reward_ff) + D_W'(g_val) - D_W'(q_ff);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            aprod_in = AP_W'(d_ff) * AP_W'($signed({1'b0, alpha_ff}));
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               chosen_in    = '0;
               random_in    = 1'b0;
               nv_in        = '0;
               expl_in      = rate_ff;
               case (cmd_ff)
                  CMD_CHOOSE: begin
                     if (draw_ff < rate_ff || eq_ff) begin
                        chosen_in = ract_ff;
                        random_in = 1'b1;
                     end else begin
                        chosen_in = ACTION_W'(best_ff);
                     end
                  end
                  CMD_UPDATE: begin
                     nv_in     = r_ext[NEWVAL_W-1:0];
                     mem_wr_en = s_ok_ff && a_ok_ff;
                  end
                  CMD_EPISODE: begin
                     if (rate_ff > DECAY_FLOOR) begin
                        rate_in = rate_ff - DECAY_STEP;
                        expl_in = rate_ff - DECAY_STEP;
                     end
                  end
                  CMD_RESTART: begin
                     rate_in = init_rate_ff;
                     expl_in = init_rate_ff;
                  end
                  default: begin
                     rate_in = rate_ff;
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Configuration writes
      if (csr_fire) begin
         case (csr_if.index)
            CSR_LEARNING_RATE:       alpha_in     = csr_if.data;
            CSR_DISCOUNT_FACTOR:     gamma_in     = csr_if.data;
            CSR_INITIAL_EXPLORATION: init_rate_in = csr_if.data[RATE_W-1:0];
            default:                 alpha_in     = alpha_ff;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= RATE_RESET;
         alpha_ff     <= ALPHA_RESET;
         gamma_ff     <= GAMMA_RESET;
         init_rate_ff <= RATE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rate_ff      <= rate_in;
         alpha_ff     <= alpha_in;
         gamma_ff     <= gamma_in;
         init_rate_ff <= init_rate_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      s_ff      <= s_in;
      a_ff      <= a_in;
      reward_ff <= reward_in;
      draw_ff   <= draw_in;
      ract_ff   <= ract_in;
      s_ok_ff   <= s_ok_in;
      a_ok_ff   <= a_ok_in;
      oob1_ff   <= oob1_in;
      max_ff    <= max_in;
      best_ff   <= best_in;
      eq_ff     <= eq_in;
      row_ff    <= row_in;
      q_ff      <= q_in;
      gprod_ff  <= gprod_in;
      d_ff      <= d_in;
      aprod_ff  <= aprod_in;
      chosen_ff <= chosen_in;
      random_ff <= random_in;
      nv_ff     <= nv_in;
      expl_ff   <= expl_in;
   end

   // Port drive
   assign req_if.ready           = (state_ff == ST_IDLE) && !clear_busy;
   assign csr_if.ready           = 1'b1;
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.chosen_action   = chosen_ff;
   assign rsp_if.was_random      = random_ff;
   assign rsp_if.new_value       = nv_ff;
   assign rsp_if.exploration_now = expl_ff;

endmodule

>>> src/qlte_table_mem.sv
// ----------------------------------------------------------------------------
// qlte_table_mem: value table storage
// One row of action values per address, registered read, single write port.
// A clearing pass after reset writes zero to every row.
// ----------------------------------------------------------------------------
module qlte_table_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic                     clear_busy
);
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] table_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic             clr_busy_ff, clr_busy_in;

   // Advance the clearing pointer until the last row
   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // Write port: clearing pass first, then normal writes
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         table_mem[clr_cnt_ff] <= '0;
      end else if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, hold data when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

>>> src/qlte_row_max.sv
// ----------------------------------------------------------------------------
// qlte_row_max: row maximum search
// Compare tree over one row: maximum, first index holding it, and an
// all-entries-equal flag.
// ----------------------------------------------------------------------------
module qlte_row_max #(
   parameter int NUM_ACTIONS = 4,
   parameter int VALUE_WIDTH = 32
) (
   input  logic [NUM_ACTIONS-1:0][VALUE_WIDTH-1:0] row,
   output logic signed [VALUE_WIDTH-1:0]           max_value,
   output logic [$clog2(NUM_ACTIONS)-1:0]          best_index,
   output logic                                    all_equal
);
   localparam int AIW    = $clog2(NUM_ACTIONS);
   localparam int LEAVES = 1 << AIW;

   logic signed [VALUE_WIDTH-1:0] node_val [1:2*LEAVES-1];
   logic [AIW-1:0]                node_idx [1:2*LEAVES-1];
   logic                          node_vld [1:2*LEAVES-1];

   // Tree: lower index wins ties so the first maximum is kept
   always_comb begin
      for (int i = 0; i < LEAVES; i++) begin
         node_vld[LEAVES+i] = (i < NUM_ACTIONS);
         node_idx[LEAVES+i] = AIW'(i);
         node_val[LEAVES+i] = '0;
         if (i < NUM_ACTIONS) begin
            node_val[LEAVES+i] = $signed(row[i]);
         end
      end
      for (int k = LEAVES - 1; k >= 1; k--) begin
         if (!node_vld[2*k+1] || (node_vld[2*k] && node_val[2*k] >= node_val[2*k+1])) begin
            node_val[k] = node_val[2*k];
            node_idx[k] = node_idx[2*k];
            node_vld[k] = node_vld[2*k];
         end else begin
            node_val[k] = node_val[2*k+1];
            node_idx[k] = node_idx[2*k+1];
            node_vld[k] = node_vld[2*k+1];
         end
      end
   end

   // Every entry against the first one
   always_comb begin
      all_equal = 1'b1;
      for (int i = 1; i < NUM_ACTIONS; i++) begin
         if (row[i] != row[0]) begin
            all_equal = 1'b0;
         end
      end
   end

   assign max_value  = node_val[1];
   assign best_index = node_idx[1];

endmodule

>>> src/qlte_checker.sv
// ----------------------------------------------------------------------------
// qlte_checker: port-level assertions for the Q-learning table engine
// Checks one-at-a-time sequencing, reset and response channel behavior.
// ----------------------------------------------------------------------------
module qlte_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [qlte_pkg::ACTION_W-1:0] rsp_chosen_action,
   input logic                          rsp_was_random,
   input logic [qlte_pkg::NEWVAL_W-1:0] rsp_new_value,
   input logic [qlte_pkg::RATE_W-1:0]   rsp_exploration_now
);
   import qlte_pkg::*;

   // One transaction at a time: no request taken right after another
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous transaction in flight");

   // Reset empties the response register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A response only appears while the block is busy
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without a transaction in flight");

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_chosen_action) &&
         $stable(rsp_was_random) && $stable(rsp_new_value) &&
         $stable(rsp_exploration_now)))
      else $error("response payload changed while stalled");

endmodule

bind q_learning_table_engine qlte_checker u_qlte_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_if.valid),
   .req_ready           (req_if.ready),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_chosen_action   (rsp_if.chosen_action),
   .rsp_was_random      (rsp_if.was_random),
   .rsp_new_value       (rsp_if.new_value),
   .rsp_exploration_now (rsp_if.exploration_now)
);

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the Q-learning table engine
// Drives choose, update, episode-end and restart transactions with random
// gaps, stalls the response side at random and for long stretches at set request counts, and
// checks every response against an in-bench copy of the table and the rate.
// ----------------------------------------------------------------------------
module testbench;
   import qlte_pkg::*;

   localparam int     ACTIONS     = 1 << ACTION_W;
   localparam longint Q_MAX       = 64'sd2147483647;
   localparam longint Q_MIN       = -64'sd2147483648;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int     PHASE_ITEMS = 425;
   localparam int     LONG_HOLD   = 400;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [STATE_W-1:0]  state_index;
      logic [ACTION_W-1:0] action_index;
      logic [REWARD_W-1:0] reward;
      logic [STATE_W-1:0]  next_state_index;
      logic [DRAW_W-1:0]   random_draw;
      logic [ACTION_W-1:0] random_action;
   } q_cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] chosen_action;
      logic                was_random;
      logic [NEWVAL_W-1:0] new_value;
      logic [RATE_W-1:0]   exploration_now;
   } q_result_type;

   logic clock;
   logic reset;

   qlte_req_if req_if ();
   qlte_rsp_if rsp_if ();
   qlte_csr_if csr_if ();

   q_learning_table_engine u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Mirror of the engine state and its registers
   logic signed [NEWVAL_W-1:0] value_tbl [0:255][0:ACTIONS-1];
   logic [RATE_W-1:0]          explore_rate;
   logic [FRAC_W-1:0]          alpha_q;
   logic [FRAC_W-1:0]          gamma_q;
   logic [RATE_W-1:0]          init_rate;

   q_cmd_type    cmd_backlog[$];
   q_result_type predicted_results[$];
   q_cmd_type    offered_cmd;

   int n_issued    = 0;
   int n_accepted  = 0;
   int n_results   = 0;
   int n_errors    = 0;
   int n_writes    = 0;
   int n_greedy    = 0;
   int n_rand_pick = 0;
   int n_saturated = 0;
   int n_holds     = 0;
   int cmd_count [0:3] = '{0, 0, 0, 0};

   int src_gap   = 0;
   bit src_idle  = 1'b1;
   int sink_wait = 0;
   bit sink_idle = 1'b1;
   int hold_left = 0;
   int hold_mark = 500;

   // floor(v * f / 65536), exact for the ranges seen here
   function automatic longint frac_scale(input longint v, input logic [FRAC_W-1:0] f);
      longint fl;
      longint prod;
      fl   = longint'(f);
      prod = v * fl;
      return prod >>> 16;
   endfunction

   // Row maximum, first column holding it, and whether all columns match
   function automatic void scan_row(input logic [STATE_W-1:0] row, output longint peak,
                                    output int best, output bit flat);
      longint v;
      peak = longint'(value_tbl[row][0]);
      best = 0;
      flat = 1'b1;
      for (int i = 1; i < ACTIONS; i++) begin
         v = longint'(value_tbl[row][i]);
         if (v != peak) flat = 1'b0;
         if (v > peak) begin
            peak = v;
            best = i;
         end
      end
   endfunction

   // Advance the mirrored engine by one command and return its response
   function automatic q_result_type apply_q_command(input q_cmd_type it);
      q_result_type res;
      longint    peak;
      longint    cur;
      longint    delta;
      longint    sum;
      int        best;
      bit        flat;
      res = '0;
      cmd_count[it.cmd]++;
      case (it.cmd)
         CMD_CHOOSE: begin
            if (it.random_draw < explore_rate) begin
               res.chosen_action = it.random_action;
               res.was_random    = 1'b1;
            end else begin
               scan_row(it.state_index, peak, best, flat);
               if (flat) begin
                  res.chosen_action = it.random_action;
                  res.was_random    = 1'b1;
               end else begin
                  res.chosen_action = best[ACTION_W-1:0];
               end
            end
            if (res.was_random) n_rand_pick++;
            else n_greedy++;
         end
         CMD_UPDATE: begin
            scan_row(it.next_state_index, peak, best, flat);
            cur   = longint'(value_tbl[it.state_index][it.action_index]);
            delta = longint'($signed(it.reward)) + frac_scale(peak, gamma_q) - cur;
            sum   = cur + frac_scale(delta, alpha_q);
            if (sum > Q_MAX) begin
               sum = Q_MAX;
               n_saturated++;
            end else if (sum < Q_MIN) begin
               sum = Q_MIN;
               n_saturated++;
            end
            value_tbl[it.state_index][it.action_index] = sum[NEWVAL_W-1:0];
            res.new_value = sum[NEWVAL_W-1:0];
         end
         CMD_EPISODE: begin
            if (explore_rate > DECAY_FLOOR) explore_rate = explore_rate - DECAY_STEP;
         end
         CMD_RESTART: begin
            explore_rate = init_rate;
         end
      endcase
      res.exploration_now = explore_rate;
      return res;
   endfunction

   // Rows mostly from a small pool so that updates and choices meet
   function automatic logic [STATE_W-1:0] pick_row();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return STATE_W'($urandom_range(0, 7));
         6, 7:             return STATE_W'($urandom_range(248, 255));
         default:          return STATE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic q_cmd_type random_cmd();
      q_cmd_type it;
      int     k;
      int     sel;
      sel = $urandom_range(0, 99);
      if (sel < 40)      it.cmd = CMD_CHOOSE;
      else if (sel < 85) it.cmd = CMD_UPDATE;
      else if (sel < 95) it.cmd = CMD_EPISODE;
      else               it.cmd = CMD_RESTART;
      it.state_index      = pick_row();
      it.next_state_index = pick_row();
      it.action_index     = ACTION_W'($urandom_range(0, ACTIONS - 1));
      it.random_action    = ACTION_W'($urandom_range(0, ACTIONS - 1));
      it.random_draw      = DRAW_W'($urandom_range(0, 1) ? $urandom_range(0, 127)
                                                         : $urandom_range(90, 127));
      case ($urandom_range(0, 7))
         0, 1: it.reward = '0;
         2, 3: begin
            k         = int'($urandom_range(0, 16)) - 8;
            it.reward = k <<< 16;
         end
         4:       it.reward = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: it.reward = $urandom;
      endcase
      return it;
   endfunction

   task automatic push_item(input q_cmd_type it);
      cmd_backlog.push_back(it);
      n_issued++;
   endtask

   task automatic directed(input logic [CMD_W-1:0] c, input int s, input int a,
                           input logic [REWARD_W-1:0] r, input int ns, input int draw,
                           input int ract);
      q_cmd_type it;
      it.cmd              = c;
      it.state_index      = STATE_W'(s);
      it.action_index     = ACTION_W'(a);
      it.reward           = r;
      it.next_state_index = STATE_W'(ns);
      it.random_draw      = DRAW_W'(draw);
      it.random_action    = ACTION_W'(ract);
      push_item(it);
   endtask

   // Register write over the CSR channel; mirror it once accepted
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_if.index <= idx;
      csr_if.data  <= val;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         CSR_LEARNING_RATE:       alpha_q   = val;
         CSR_DISCOUNT_FACTOR:     gamma_q   = val;
         CSR_INITIAL_EXPLORATION: init_rate = val[RATE_W-1:0];
         default: ;
      endcase
      n_writes++;
   endtask

   task automatic set_config(input logic [FRAC_W-1:0] a, input logic [FRAC_W-1:0] g,
                             input logic [RATE_W-1:0] r);
      write_reg(CSR_LEARNING_RATE, a);
      write_reg(CSR_DISCOUNT_FACTOR, g);
      write_reg(CSR_INITIAL_EXPLORATION, CSR_DATA_W'(r));
   endtask

   // Wait until every issued transaction has come back, then let the engine settle
   task automatic drain();
      do @(posedge clock); while (n_results < n_issued);
      repeat (8) @(posedge clock);
   endtask

   task automatic random_phase(input int count);
      repeat (count) push_item(random_cmd());
      drain();
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Request driver: offer backlog items, hold while stalled, gap between items
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         src_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predicted_results.push_back(apply_q_command(offered_cmd));
            n_accepted <= n_accepted + 1;
         end
         if (!req_if.valid || req_if.ready) begin
            if (src_gap != 0) begin
               src_gap--;
               req_if.valid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
               offered_cmd = cmd_backlog.pop_front();
               req_if.cmd              <= offered_cmd.cmd;
               req_if.state_index      <= offered_cmd.state_index;
               req_if.action_index     <= offered_cmd.action_index;
               req_if.reward           <= offered_cmd.reward;
               req_if.next_state_index <= offered_cmd.next_state_index;
               req_if.random_draw      <= offered_cmd.random_draw;
               req_if.random_action    <= offered_cmd.random_action;
               req_if.valid            <= 1'b1;
               if ($urandom_range(0, 63) == 0) src_idle = !src_idle;
               src_gap = src_idle ? $urandom_range(0, 7) : 0;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Long hold-off of the response side, started by the request count
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (n_accepted >= hold_mark) begin
         hold_left <= LONG_HOLD;
         hold_mark <= hold_mark + 700;
         n_holds   <= n_holds + 1;
      end
   end

   // Response monitor: compare each transaction with the oldest prediction
   always @(posedge clock) begin
      q_result_type observed;
      q_result_type wanted;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         sink_wait = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            observed = {rsp_if.chosen_action, rsp_if.was_random, rsp_if.new_value,
                        rsp_if.exploration_now};
            if (predicted_results.size() == 0) begin
               $display("%0t: unexpected response action=%0d rnd=%0d value=%h rate=%0d",
                        $time, observed.chosen_action, observed.was_random,
                        observed.new_value, observed.exploration_now);
               n_errors++;
            end else begin
               wanted = predicted_results.pop_front();
               if (observed !== wanted) begin
                  $display("%0t: mismatch expected action=%0d rnd=%0d value=%h rate=%0d",
                           $time, wanted.chosen_action, wanted.was_random,
                           wanted.new_value, wanted.exploration_now);
                  $display("%0t:            actual action=%0d rnd=%0d value=%h rate=%0d",
                           $time, observed.chosen_action, observed.was_random,
                           observed.new_value, observed.exploration_now);
                  n_errors++;
               end
            end
            n_results <= n_results + 1;
            if ($urandom_range(0, 63) == 0) sink_idle = !sink_idle;
            sink_wait = sink_idle ? $urandom_range(0, 7) : 0;
         end
         if (sink_wait != 0) begin
            sink_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= (hold_left == 0);
         end
      end
   end

   // Stimulus sequence
   initial begin
      reset                   = 1'b1;
      req_if.valid            = 1'b0;
      req_if.cmd              = '0;
      req_if.state_index      = '0;
      req_if.action_index     = '0;
      req_if.reward           = '0;
      req_if.next_state_index = '0;
      req_if.random_draw      = '0;
      req_if.random_action    = '0;
      rsp_if.ready            = 1'b0;
      csr_if.valid            = 1'b0;
      csr_if.index            = '0;
      csr_if.data             = '0;
      foreach (value_tbl[s, a]) value_tbl[s][a] = '0;
      explore_rate = RATE_RESET;
      alpha_q      = ALPHA_RESET;
      gamma_q      = GAMMA_RESET;
      init_rate    = RATE_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: exploring, tie on an empty row, greedy, extreme rewards
      set_config(ALPHA_RESET, GAMMA_RESET, RATE_RESET);
      directed(CMD_CHOOSE, 0, 0, '0, 0, 99, 3);
      directed(CMD_CHOOSE, 0, 1, '0, 0, 100, 2);
      directed(CMD_UPDATE, 5, 2, 32'h7FFF_FFFF, 5, 0, 0);
      directed(CMD_UPDATE, 5, 2, 32'h7FFF_FFFF, 5, 127, 3);
      directed(CMD_CHOOSE, 5, 3, '0, 255, 127, 1);
      directed(CMD_UPDATE, 5, 0, 32'h8000_0000, 255, 0, 0);
      directed(CMD_UPDATE, 255, 3, 32'h0001_0000, 5, 0, 0);
      directed(CMD_EPISODE, 255, 3, 32'hFFFF_FFFF, 255, 127, 3);
      drain();

      // Full-scale alpha and gamma, zero exploration: saturate both ways
      set_config(16'hFFFF, 16'hFFFF, 7'd0);
      directed(CMD_RESTART, 0, 0, '0, 0, 0, 0);
      directed(CMD_UPDATE, 7, 1, 32'h7FFF_FFFF, 5, 0, 0);
      directed(CMD_UPDATE, 7, 1, 32'h7FFF_FFFF, 5, 0, 0);
      for (int a = 0; a < ACTIONS; a++) directed(CMD_UPDATE, 10, a, 32'h8000_0000, 200, 0, 0);
      directed(CMD_UPDATE, 11, 0, 32'h8000_0000, 10, 0, 0);
      directed(CMD_CHOOSE, 10, 0, '0, 0, 0, 1);
      directed(CMD_CHOOSE, 7, 0, '0, 0, 0, 2);
      directed(CMD_EPISODE, 0, 0, '0, 0, 0, 0);
      drain();

      // Decay just above the floor: 11 drops to 9 and stays
      set_config(16'hFFFF, 16'hFFFF, 7'd11);
      directed(CMD_RESTART, 0, 0, '0, 0, 0, 0);
      directed(CMD_EPISODE, 0, 0, '0, 0, 0, 0);
      directed(CMD_EPISODE, 0, 0, '0, 0, 0, 0);
      drain();

      // Zero alpha and gamma leave the entry as it is; 12 decays to the floor
      set_config(16'h0000, 16'h0000, 7'd12);
      write_reg(CSR_SPARE, 16'hFFFF);
      directed(CMD_RESTART, 0, 0, '0, 0, 0, 0);
      directed(CMD_EPISODE, 0, 0, '0, 0, 0, 0);
      directed(CMD_EPISODE, 0, 0, '0, 0, 0, 0);
      directed(CMD_UPDATE, 7, 1, 32'h7FFF_FFFF, 7, 0, 0);
      drain();

      // Random traffic under several settings
      set_config(ALPHA_RESET, GAMMA_RESET, RATE_RESET);
      random_phase(PHASE_ITEMS);
      set_config(FRAC_W'($urandom_range(0, 65535)), FRAC_W'($urandom_range(0, 65535)),
                 RATE_W'($urandom_range(0, 100)));
      random_phase(PHASE_ITEMS);
      set_config(16'hFFFF, 16'h0000, 7'd50);
      random_phase(PHASE_ITEMS);
      set_config(FRAC_W'($urandom_range(0, 65535)), FRAC_W'($urandom_range(0, 65535)),
                 RATE_W'($urandom_range(0, 100)));
      random_phase(PHASE_ITEMS);

      repeat (20) @(posedge clock);
      $display("Covered %0d requests (choose %0d, update %0d, episode %0d, restart %0d),",
               n_accepted, cmd_count[CMD_CHOOSE], cmd_count[CMD_UPDATE],
               cmd_count[CMD_EPISODE], cmd_count[CMD_RESTART]);
      $display("%0d CSR writes; choices: %0d greedy, %0d random or tied; %0d saturated; %0d long stalls.",
               n_writes, n_greedy, n_rand_pick, n_saturated, n_holds);
      if (n_errors == 0 && predicted_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
